// File: rtl/core/smn64_pkg.sv
// ----------------------------------------------------------------------------
// smn64_pkg
// Shared types, constants and word functions of the Simon64 cipher core.
// ----------------------------------------------------------------------------
package smn64_pkg;

    typedef logic [31:0] t_word;
    typedef logic [2:0]  t_kc_mode;

    // Key cell moves: hold, or load from a neighbor one or two places away.
    localparam t_kc_mode KC_HOLD = 3'd0;
    localparam t_kc_mode KC_NXT1 = 3'd1;
    localparam t_kc_mode KC_NXT2 = 3'd2;
    localparam t_kc_mode KC_PRV1 = 3'd3;
    localparam t_kc_mode KC_PRV2 = 3'd4;

    // z sequences, first element in the most significant bit.
    localparam logic [61:0] Z2_SEQ =
        62'b10101111011100000011010010011000101000010001111110010110110011;
    localparam logic [61:0] Z3_SEQ =
        62'b11011011101011000110010111100000010010001010011100110100001111;

    localparam t_word KS_CONST = 32'hFFFF_FFFC;

    function automatic t_word rotl(input t_word v, input int n);
        rotl = (v << n) | (v >> (32 - n));
    endfunction

    function automatic t_word rotr(input t_word v, input int n);
        rotr = (v >> n) | (v << (32 - n));
    endfunction

    function automatic t_word round_f(input t_word x);
        round_f = (rotl(x, 1) & rotl(x, 8)) ^ rotl(x, 2);
    endfunction

endpackage

// File: rtl/core/smn64_key_cell.sv
// ----------------------------------------------------------------------------
// smn64_key_cell
// One round key cell of the rotating key chain.
// ----------------------------------------------------------------------------
module smn64_key_cell
    import smn64_pkg::*;
(
    input  logic     i_clk,
    input  t_kc_mode i_mode,
    input  t_word    i_nxt1,
    input  t_word    i_nxt2,
    input  t_word    i_prv1,
    input  t_word    i_prv2,
    output t_word    o_key
);

    t_word r_key;
    t_word n_key;

    always_comb begin
        case (i_mode)
            KC_NXT1: n_key = i_nxt1;
            KC_NXT2: n_key = i_nxt2;
            KC_PRV1: n_key = i_prv1;
            KC_PRV2: n_key = i_prv2;
            default: n_key = r_key;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    assign o_key = r_key;

endmodule

// File: rtl/core/smn64_round.sv
// ----------------------------------------------------------------------------
// smn64_round
// One or two Feistel rounds, forward or inverse.
// ----------------------------------------------------------------------------
module smn64_round
    import smn64_pkg::*;
(
    input  t_word i_x,
    input  t_word i_y,
    input  t_word i_key_a,
    input  t_word i_key_b,
    input  logic  i_decrypt,
    input  logic  i_double,
    output t_word o_x,
    output t_word o_y
);

    t_word w_x1, w_y1, w_x2, w_y2;

    always_comb begin
        if (i_decrypt) begin
            w_x1 = i_y;
            w_y1 = i_x ^ round_f(i_y) ^ i_key_a;
            w_x2 = w_y1;
            w_y2 = w_x1 ^ round_f(w_y1) ^ i_key_b;
        end else begin
            w_y1 = i_x;
            w_x1 = i_y ^ round_f(i_x) ^ i_key_a;
            w_y2 = w_x1;
            w_x2 = w_y1 ^ round_f(w_x1) ^ i_key_b;
        end
    end

    assign o_x = i_double ? w_x2 : w_x1;
    assign o_y = i_double ? w_y2 : w_y1;

endmodule

// File: rtl/core/simon64_block_cipher_core.sv
// ----------------------------------------------------------------------------
// simon64_block_cipher_core
// Simon64 block cipher with a rotating chain of round key cells.
// ----------------------------------------------------------------------------
//  channel | valid       | stall        | payload
//  in      | i_in_valid  | o_in_stall   | i_req_type, i_block_low, i_block_high
//  out     | o_out_valid | i_out_stall  | o_result_low, o_result_high
//  cfg     | i_cfg_we    | -            | i_cfg_index, i_cfg_data
//
// A block passes through the round unit at two rounds a cycle (one round in
// a last step when ROUNDS is odd), with one key pair read from the ends of the
// key chain, then loads the output register. The first block after reset or a
// key write first expands the key, one round key per cycle. The key chain rotates
// back to its rest position at the end of every block. Reset is synchronous;
// the input stalls while a block is in work, and a held output beat keeps the
// next result, and with it the input stall, in the final state until it is taken.
// ----------------------------------------------------------------------------
module simon64_block_cipher_core
    import smn64_pkg::*;
#(
    parameter int KEY_WORDS = 4,
    parameter int ROUNDS    = 44
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_req_type,
    input  logic [31:0] i_block_low,
    input  logic [31:0] i_block_high,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_result_low,
    output logic [31:0] o_result_high,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int CW = $clog2(ROUNDS + 1);
    localparam logic [61:0] Z_SEQ = (KEY_WORDS == 4) ? Z3_SEQ : Z2_SEQ;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EXPAND = 2'd1;
    localparam logic [1:0] S_RUN    = 2'd2;
    localparam logic [1:0] S_FIN    = 2'd3;

    logic [1:0]    r_state;
    logic          r_sched_ok;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_left;
    logic          r_dec;
    t_word         r_x, r_y;
    t_word         r_key [4];
    logic          r_out_valid;
    t_word         r_out_x, r_out_y;

    t_word    w_cell [ROUNDS];
    t_word    w_new;
    t_word    w_t;
    t_word    w_chain_in;
    logic [5:0] w_zidx;
    t_kc_mode w_mode;
    logic     w_two;
    logic     w_accept;
    logic     w_out_free;
    t_word    w_rx, w_ry;

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_two      = (r_left >= CW'(2));

    // Next round key: r_key for the first KEY_WORDS, else from the newest cells.
    always_comb begin
        w_zidx = 6'(r_cnt - CW'(KEY_WORDS));
        w_t = rotr(w_cell[ROUNDS-1], 3);
        if (KEY_WORDS == 4) begin
            w_t = w_t ^ w_cell[ROUNDS-3];
        end
        w_t = w_t ^ rotr(w_t, 1);
        w_t = w_t ^ KS_CONST ^ w_cell[ROUNDS-KEY_WORDS];
        w_t = w_t ^ {31'd0, Z_SEQ[6'd61 - w_zidx]};
        if (r_cnt < CW'(KEY_WORDS)) begin
            w_new = r_key[r_cnt[1:0]];
        end else begin
            w_new = w_t;
        end
    end

    assign w_chain_in = (r_state == S_EXPAND) ? w_new : w_cell[0];

    always_comb begin
        case (r_state)
            S_EXPAND: w_mode = KC_NXT1;
            S_RUN: begin
                if (r_dec) begin
                    w_mode = w_two ? KC_PRV2 : KC_PRV1;
                end else begin
                    w_mode = w_two ? KC_NXT2 : KC_NXT1;
                end
            end
            default: w_mode = KC_HOLD;
        endcase
    end

    for (genvar g = 0; g < ROUNDS; g++) begin : g_cell
        localparam int N1 = (g + 1) % ROUNDS;
        localparam int N2 = (g + 2) % ROUNDS;
        localparam int P1 = (g + ROUNDS - 1) % ROUNDS;
        localparam int P2 = (g + ROUNDS - 2) % ROUNDS;
        t_word w_n1;
        if (g == ROUNDS - 1) begin : g_tail
            assign w_n1 = w_chain_in;
        end else begin : g_body
            assign w_n1 = w_cell[N1];
        end
        smn64_key_cell u_cell (
            .i_clk  (i_clk),
            .i_mode (w_mode),
            .i_nxt1 (w_n1),
            .i_nxt2 (w_cell[N2]),
            .i_prv1 (w_cell[P1]),
            .i_prv2 (w_cell[P2]),
            .o_key  (w_cell[g])
        );
    end

    smn64_round u_round (
        .i_x       (r_x),
        .i_y       (r_y),
        .i_key_a   (r_dec ? w_cell[ROUNDS-1] : w_cell[0]),
        .i_key_b   (r_dec ? w_cell[ROUNDS-2] : w_cell[1]),
        .i_decrypt (r_dec),
        .i_double  (w_two),
        .o_x       (w_rx),
        .o_y       (w_ry)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sched_ok  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_left      <= '0;
            r_key[0]    <= '0;
            r_key[1]    <= '0;
            r_key[2]    <= '0;
            r_key[3]    <= '0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we && (i_cfg_index < 3'd4)) begin
                r_key[i_cfg_index[1:0]] <= i_cfg_data;
                r_sched_ok <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_x    <= i_block_high;
                        r_y    <= i_block_low;
                        r_dec  <= i_req_type;
                        r_left <= CW'(ROUNDS);
                        r_cnt  <= '0;
                        r_state <= r_sched_ok ? S_RUN : S_EXPAND;
                    end
                end
                S_EXPAND: begin
                    r_cnt <= r_cnt + CW'(1);
                    if (r_cnt == CW'(ROUNDS - 1)) begin
                        r_sched_ok <= 1'b1;
                        r_state    <= S_RUN;
                    end
                end
                S_RUN: begin
                    r_x    <= w_rx;
                    r_y    <= w_ry;
                    r_left <= r_left - (w_two ? CW'(2) : CW'(1));
                    if (r_left <= CW'(2)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_out_x     <= r_x;
                        r_out_y     <= r_y;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_result_low  = r_out_y;
    assign o_result_high = r_out_x;

endmodule

// File: bench/simon64_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// simon64_checker
// Watches the key port and both beat channels of the Simon64 core, predicts
// each transformed block from its own key schedule and compares in order.
// ----------------------------------------------------------------------------
module simon64_checker
    import smn64_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic        i_req_type,
    input  logic [31:0] i_block_low,
    input  logic [31:0] i_block_high,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [31:0] i_result_low,
    input  logic [31:0] i_result_high,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int NUM_KEYS   = 4;
    localparam int NUM_ROUNDS = 44;
    localparam logic [2:0] LAST_KEY_INDEX = 3'd3;

    typedef struct packed {
        t_word lo;
        t_word hi;
    } t_block;

    t_word  key_words [NUM_KEYS];
    t_block expected_blocks [$];

    function automatic t_word rot_left(input t_word v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic t_word mix_word(input t_word v);
        return (rot_left(v, 1) & rot_left(v, 8)) ^ rot_left(v, 2);
    endfunction

    function automatic t_block cipher_block(input logic decrypt, input t_block blk);
        t_word rk [NUM_ROUNDS];
        t_word t;
        t_word x;
        t_word y;
        for (int i = 0; i < NUM_ROUNDS; i++) begin
            if (i < NUM_KEYS) begin
                rk[i] = key_words[i];
            end else begin
                t = rot_left(rk[i-1], 29) ^ rk[i-3];
                t = t ^ rot_left(t, 31);
                t = t ^ KS_CONST ^ rk[i-NUM_KEYS];
                // The z sequence is stored first element in the top bit.
                if (Z3_SEQ[61 - ((i - NUM_KEYS) % 62)])
                    t = t ^ 32'h1;
                rk[i] = t;
            end
        end
        x = blk.hi;
        y = blk.lo;
        if (!decrypt) begin
            for (int i = 0; i < NUM_ROUNDS; i++) begin
                t = x;
                x = y ^ mix_word(x) ^ rk[i];
                y = t;
            end
        end else begin
            for (int i = NUM_ROUNDS - 1; i >= 0; i--) begin
                t = y;
                y = x ^ mix_word(y) ^ rk[i];
                x = t;
            end
        end
        return '{lo: y, hi: x};
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        foreach (key_words[k]) key_words[k] = '0;
    end

    always @(posedge i_clk) begin
        t_block exp_blk;
        if (!i_rst_n) begin
            foreach (key_words[k]) key_words[k] = '0;
        end else begin
            // Key words only change while the core is idle, so order is free.
            if (i_cfg_we && i_cfg_index <= LAST_KEY_INDEX)
                key_words[i_cfg_index[1:0]] = i_cfg_data;
            if (i_in_valid && !i_in_stall)
                expected_blocks.push_back(cipher_block(i_req_type,
                    '{lo: i_block_low, hi: i_block_high}));
            if (i_out_valid && !i_out_stall) begin
                if (expected_blocks.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("%0t: unexpected result beat lo=%h hi=%h",
                                 $realtime, i_result_low, i_result_high);
                end else begin
                    exp_blk = expected_blocks.pop_front();
                    if (exp_blk.lo !== i_result_low || exp_blk.hi !== i_result_high) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("%0t: result mismatch exp lo=%h hi=%h got lo=%h hi=%h",
                                     $realtime, exp_blk.lo, exp_blk.hi,
                                     i_result_low, i_result_high);
                    end
                end
            end
            o_pending = expected_blocks.size();
        end
    end

endmodule

// File: bench/tb_simon64_block_cipher_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_simon64_block_cipher_core
// Drives key phases and encrypt/decrypt blocks into the Simon64 core with
// random gaps and output stalls; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_simon64_block_cipher_core;
    import smn64_pkg::*;

    localparam logic       DIR_ENCRYPT = 1'b0;
    localparam logic       DIR_DECRYPT = 1'b1;
    localparam logic [2:0] IDX_KEY0 = 3'd0;
    localparam logic [2:0] IDX_KEY1 = 3'd1;
    localparam logic [2:0] IDX_KEY2 = 3'd2;
    localparam logic [2:0] IDX_KEY3 = 3'd3;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 120;
    localparam int RANDOM_PHASES  = 7;
    localparam int PHASE_ITEMS    = 147;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        req_type = 1'b0;
    logic [31:0] block_low = '0;
    logic [31:0] block_high = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] result_low;
    logic [31:0] result_high;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    int  fail_count;
    int  pending;
    bit  quiet_tail = 1'b0;
    int  stall_left = 0;
    int  idle_cycles = 0;

    always #1 clk = ~clk;

    simon64_block_cipher_core i_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_req_type(req_type), .i_block_low(block_low), .i_block_high(block_high),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_result_low(result_low), .o_result_high(result_high),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    simon64_checker i_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_req_type(req_type), .i_block_low(block_low), .i_block_high(block_high),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_result_low(result_low), .i_result_high(result_high),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Receiver stalls come in bursts, and stop for the last part of the run.
    always @(posedge clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 10);
            out_stall  <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // Called at a rising edge; returns at the edge that accepted the beat, or after a random gap that follows it.
    task automatic send_block(input logic dir, input logic [31:0] lo,
                              input logic [31:0] hi, input bit allow_gap);
        in_valid   <= 1'b1;
        req_type   <= dir;
        block_low  <= lo;
        block_high <= hi;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (allow_gap && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
    endtask

    // Drains the core, then loads a new key; a write to an unused index rides along.
    task automatic load_key(input logic [31:0] k0, input logic [31:0] k1,
                            input logic [31:0] k2, input logic [31:0] k3);
        logic [2:0]  idx [5];
        logic [31:0] val [5];
        idx = '{IDX_KEY0, IDX_KEY1, IDX_KEY2, IDX_KEY3, 3'($urandom_range(4, 7))};
        val = '{k0, k1, k2, k3, $urandom()};
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        for (int i = 0; i < 5; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset key of all zeros, then the published Simon64/128 vector.
        send_block(DIR_ENCRYPT, 32'h0, 32'h0, 1'b0);
        send_block(DIR_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        load_key(32'h0302_0100, 32'h0b0a_0908, 32'h1312_1110, 32'h1b1a_1918);
        send_block(DIR_ENCRYPT, 32'h2064_6e75, 32'h656b_696c, 1'b0);
        send_block(DIR_DECRYPT, 32'hb9df_a07a, 32'h44c8_fc20, 1'b0);
        send_block(DIR_ENCRYPT, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
        send_block(DIR_DECRYPT, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
        load_key('1, '1, '1, '1);
        send_block(DIR_ENCRYPT, 32'h0, 32'h0, 1'b0);
        send_block(DIR_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_block(DIR_DECRYPT, 32'h0, 32'hFFFF_FFFF, 1'b0);
        send_block(DIR_DECRYPT, 32'hFFFF_FFFF, 32'h0, 1'b0);
        load_key(32'h8000_0001, 32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFE);
        send_block(DIR_ENCRYPT, 32'h0000_0001, 32'h8000_0000, 1'b1);
        send_block(DIR_DECRYPT, 32'h8000_0000, 32'h0000_0001, 1'b1);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            load_key(pick_word(), pick_word(), pick_word(), pick_word());
            if (p == RANDOM_PHASES - 1)
                quiet_tail = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_block(1'($urandom_range(0, 1)), pick_word(), pick_word(), !quiet_tail);
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
